@@ src/slet_pkg.sv @@
// ----------------------------------------------------------------------------
// slet_pkg
// shared types and codes for the sorted lifetime entry table
// ----------------------------------------------------------------------------
package slet_pkg;

  // operation codes
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_TICK   = 3'd1;
  localparam logic [2:0] MODE_PURGE  = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // one table entry
  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] start;
    logic [15:0] remaining;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture the item and clear the scan
    logic scan;     // step one slot
    logic finish;   // commit and present the result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

@@ src/slet_ctrl.sv @@
// ----------------------------------------------------------------------------
// slet_ctrl
// sequencer: load the item, walk the slots, then finish
// ----------------------------------------------------------------------------
module slet_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output slet_pkg::cmd_t   cmd,
  input  slet_pkg::stat_t  stat
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t state_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) state_r <= S_SCAN;
        S_SCAN: if (stat.scan_done) state_r <= S_FIN;
        S_FIN:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // commands
  always_comb begin
    busy       = (state_r != S_IDLE);
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.scan   = (state_r == S_SCAN) && !stat.scan_done;
    cmd.finish = (state_r == S_FIN);
  end

endmodule

@@ src/slet_dp.sv @@
// ----------------------------------------------------------------------------
// slet_dp
// slot storage and the one-slot-per-cycle walker
// ----------------------------------------------------------------------------
module slet_dp #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  slet_pkg::cmd_t   cmd,
  output slet_pkg::stat_t  stat,
  input  logic [2:0]       in_mode,
  input  logic [7:0]       in_key_x,
  input  logic [7:0]       in_key_y,
  input  logic [15:0]      in_lifetime,
  input  logic [3:0]       in_read_index,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [4:0]       out_removed_count,
  output logic             out_entry_valid,
  output logic [7:0]       out_entry_x,
  output logic [7:0]       out_entry_y,
  output logic [15:0]      out_entry_start,
  output logic [15:0]      out_entry_remaining,
  output logic [4:0]       out_occupancy
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // single slot array, read and rewritten in place by the walker one slot per scan cycle
  slet_pkg::entry_t slots_r [DEPTH];

  logic [2:0]       mode_r;
  logic [7:0]       kx_r, ky_r;
  logic [15:0]      life_r;
  logic [3:0]       ridx_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    rd_r, rd_nxt;     // source slot
  logic [CW-1:0]    wr_r, wr_nxt;     // destination slot
  logic             hit_r, hit_nxt;   // key found (insert / remove)
  logic             placed_r, placed_nxt;
  logic [CW-1:0]    removed_r, removed_nxt;
  slet_pkg::entry_t carry_r, carry_nxt;  // displaced entry during insert
  logic             carry_v_r, carry_v_nxt;
  logic [CW-1:0]    hitpos_r, hitpos_nxt;

  slet_pkg::entry_t cur, newe;
  logic             in_range, match;

  // key search runs as a first pass; the rewrite pass starts after it
  logic             pass2_r, pass2_nxt;

  assign in_range = (rd_r < count_r);
  assign cur      = slots_r[rd_r[IW-1:0]];
  assign match    = in_range && (cur.x == kx_r) && (cur.y == ky_r);
  assign newe     = '{x: kx_r, y: ky_r, start: life_r, remaining: life_r};

  // walker next state
  always_comb begin
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    hit_nxt     = hit_r;
    placed_nxt  = placed_r;
    removed_nxt = removed_r;
    carry_nxt   = carry_r;
    carry_v_nxt = carry_v_r;
    hitpos_nxt  = hitpos_r;
    pass2_nxt   = pass2_r;
    stat.scan_done = 1'b0;
    unique case (mode_r)
      slet_pkg::MODE_INSERT, slet_pkg::MODE_REMOVE: begin
        if (!pass2_r) begin
          if (match && !hit_r) begin
            hit_nxt    = 1'b1;
            hitpos_nxt = rd_r;
          end
          if (in_range) rd_nxt = rd_r + 1'b1;
          else begin
            pass2_nxt = 1'b1;
            rd_nxt    = '0;
            wr_nxt    = '0;
            if (mode_r == slet_pkg::MODE_INSERT && hit_r) stat.scan_done = 1'b1;
            if (mode_r == slet_pkg::MODE_INSERT && count_r >= CW'(DEPTH))
              stat.scan_done = 1'b1;
            if (mode_r == slet_pkg::MODE_REMOVE && !hit_r) stat.scan_done = 1'b1;
          end
        end else if (mode_r == slet_pkg::MODE_REMOVE) begin
          // shift down from the hit slot
          if (rd_r + 1'b1 < count_r) rd_nxt = rd_r + 1'b1;
          else stat.scan_done = 1'b1;
        end else begin
          // insert: walk, dropping the new entry in at its place
          if (rd_r > count_r) stat.scan_done = 1'b1;
          else rd_nxt = rd_r + 1'b1;
        end
      end
      slet_pkg::MODE_TICK: begin
        if (in_range) rd_nxt = rd_r + 1'b1;
        else stat.scan_done = 1'b1;
      end
      slet_pkg::MODE_PURGE: begin
        if (in_range) begin
          rd_nxt = rd_r + 1'b1;
          if (cur.remaining == 16'd0) removed_nxt = removed_r + 1'b1;
          else wr_nxt = wr_r + 1'b1;
        end else stat.scan_done = 1'b1;
      end
      default: stat.scan_done = 1'b1;
    endcase
    // insert carry chain
    if (mode_r == slet_pkg::MODE_INSERT && pass2_r && rd_r <= count_r) begin
      if (carry_v_r) begin
        carry_nxt   = cur;
        carry_v_nxt = in_range;
      end else if (!placed_r && (rd_r == count_r || cur.remaining >= life_r)) begin
        carry_nxt   = cur;
        carry_v_nxt = in_range;
        placed_nxt  = 1'b1;
      end
    end
  end

  // slot writes
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      unique case (mode_r)
        slet_pkg::MODE_TICK: begin
          if (in_range && cur.remaining != 16'd0)
            slots_r[rd_r[IW-1:0]].remaining <= cur.remaining - 16'd1;
        end
        slet_pkg::MODE_PURGE: begin
          if (in_range && cur.remaining != 16'd0)
            slots_r[wr_r[IW-1:0]] <= cur;
        end
        slet_pkg::MODE_REMOVE: begin
          if (pass2_r && rd_r >= hitpos_r && rd_r + 1'b1 < count_r)
            slots_r[rd_r[IW-1:0]] <= slots_r[IW'(rd_r + 1'b1)];
        end
        slet_pkg::MODE_INSERT: begin
          if (pass2_r && rd_r <= count_r) begin
            if (carry_v_r) slots_r[rd_r[IW-1:0]] <= carry_r;
            else if (!placed_r && (rd_r == count_r || cur.remaining >= life_r))
              slots_r[rd_r[IW-1:0]] <= newe;
          end
        end
        default: ;
      endcase
    end
  end

  // walker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.load) begin
        mode_r    <= in_mode;
        kx_r      <= in_key_x;
        ky_r      <= in_key_y;
        life_r    <= in_lifetime;
        ridx_r    <= in_read_index;
        rd_r      <= '0;
        wr_r      <= '0;
        hit_r     <= 1'b0;
        placed_r  <= 1'b0;
        removed_r <= '0;
        carry_v_r <= 1'b0;
        pass2_r   <= 1'b0;
        hitpos_r  <= '0;
      end else if (cmd.scan) begin
        rd_r      <= rd_nxt;
        wr_r      <= wr_nxt;
        hit_r     <= hit_nxt;
        placed_r  <= placed_nxt;
        removed_r <= removed_nxt;
        carry_r   <= carry_nxt;
        carry_v_r <= carry_v_nxt;
        pass2_r   <= pass2_nxt;
        hitpos_r  <= hitpos_nxt;
      end
      if (cmd.finish) begin
        out_status          <= slet_pkg::ST_OK;
        out_removed_count   <= '0;
        out_entry_valid     <= 1'b0;
        out_entry_x         <= '0;
        out_entry_y         <= '0;
        out_entry_start     <= '0;
        out_entry_remaining <= '0;
        out_occupancy       <= 5'(count_r);
        unique case (mode_r)
          slet_pkg::MODE_INSERT: begin
            if (hit_r) out_status <= slet_pkg::ST_DUP;
            else if (count_r >= CW'(DEPTH)) out_status <= slet_pkg::ST_FULL;
            else begin
              count_r       <= count_r + 1'b1;
              out_occupancy <= 5'(count_r + 1'b1);
            end
          end
          slet_pkg::MODE_PURGE: begin
            count_r           <= wr_r;
            out_occupancy     <= 5'(wr_r);
            out_removed_count <= 5'(removed_r);
          end
          slet_pkg::MODE_REMOVE: begin
            if (!hit_r) out_status <= slet_pkg::ST_MISSING;
            else begin
              count_r       <= count_r - 1'b1;
              out_occupancy <= 5'(count_r - 1'b1);
            end
          end
          slet_pkg::MODE_READ: begin
            if ({{(CW > 4 ? CW-4 : 0){1'b0}}, ridx_r} < count_r
                && 32'(ridx_r) < DEPTH) begin
              out_entry_valid     <= 1'b1;
              out_entry_x         <= slots_r[ridx_r[IW-1:0]].x;
              out_entry_y         <= slots_r[ridx_r[IW-1:0]].y;
              out_entry_start     <= slots_r[ridx_r[IW-1:0]].start;
              out_entry_remaining <= slots_r[ridx_r[IW-1:0]].remaining;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ src/sorted_lifetime_entry_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_lifetime_entry_table_core
// sorted aging table: insert, tick, purge, remove and read, one item at a time
// ----------------------------------------------------------------------------
// the slot walker steps one slot a cycle while it scans; out_valid is registered
// from the finish state that follows the end of the walk
// insert and remove search, then rewrite unless dup, full or missing; tick and purge walk once; read does not walk
// one item at a time: the next start is taken when busy falls
// reset: synchronous, empties the table; result shown one cycle on out_valid
module sorted_lifetime_entry_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_key_x,
  input  logic [7:0]  in_key_y,
  input  logic [15:0] in_lifetime,
  input  logic [3:0]  in_read_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_removed_count,
  output logic        out_entry_valid,
  output logic [7:0]  out_entry_x,
  output logic [7:0]  out_entry_y,
  output logic [15:0] out_entry_start,
  output logic [15:0] out_entry_remaining,
  output logic [4:0]  out_occupancy
);

  slet_pkg::cmd_t  cmd;
  slet_pkg::stat_t stat;

  // sequencer
  slet_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  // storage and walker
  slet_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_mode(in_mode), .in_key_x(in_key_x), .in_key_y(in_key_y),
    .in_lifetime(in_lifetime), .in_read_index(in_read_index),
    .out_valid(out_valid), .out_status(out_status),
    .out_removed_count(out_removed_count), .out_entry_valid(out_entry_valid),
    .out_entry_x(out_entry_x), .out_entry_y(out_entry_y),
    .out_entry_start(out_entry_start), .out_entry_remaining(out_entry_remaining),
    .out_occupancy(out_occupancy)
  );

endmodule

@@ bench/tb_sorted_lifetime_entry_table_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_lifetime_entry_table_core
// drives random and directed table operations through the command handshake
// and compares each result against a behavioral copy of the sorted table
// ----------------------------------------------------------------------------
module tb_sorted_lifetime_entry_table_core;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  kx;
    logic [7:0]  ky;
    logic [15:0] life;
    logic [3:0]  ridx;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  removed;
    logic        valid;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [15:0] es;
    logic [15:0] er;
    logic [4:0]  occ;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [7:0]  in_key_x = '0;
  logic [7:0]  in_key_y = '0;
  logic [15:0] in_lifetime = '0;
  logic [3:0]  in_read_index = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [4:0]  out_removed_count;
  logic        out_entry_valid;
  logic [7:0]  out_entry_x;
  logic [7:0]  out_entry_y;
  logic [15:0] out_entry_start;
  logic [15:0] out_entry_remaining;
  logic [4:0]  out_occupancy;

  sorted_lifetime_entry_table_core #(.TABLE_DEPTH(DEPTH)) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  op_t               pending_ops[$];
  res_t              expected_results[$];
  slet_pkg::entry_t  table_model[DEPTH];
  int                live_count;
  int                error_count;
  int                cycle_count;
  int                send_idle_pct;

  // behavioral table: returns the result of one item and updates contents
  function automatic res_t apply_op(op_t op);
    res_t r;
    int   hit;
    int   pos;
    int   j;
    r = '0;
    hit = -1;
    for (int i = 0; i < live_count; i++)
      if (hit < 0 && table_model[i].x == op.kx && table_model[i].y == op.ky) hit = i;
    case (op.mode)
      slet_pkg::MODE_INSERT: begin
        if (hit >= 0) r.status = slet_pkg::ST_DUP;
        else if (live_count >= DEPTH) r.status = slet_pkg::ST_FULL;
        else begin
          pos = live_count;
          for (int i = live_count - 1; i >= 0; i--)
            if (table_model[i].remaining >= op.life) pos = i;
          for (int i = live_count; i > pos; i--) table_model[i] = table_model[i-1];
          table_model[pos] = '{op.kx, op.ky, op.life, op.life};
          live_count++;
        end
      end
      slet_pkg::MODE_TICK: begin
        for (int i = 0; i < live_count; i++)
          if (table_model[i].remaining != 0) table_model[i].remaining--;
      end
      slet_pkg::MODE_PURGE: begin
        j = 0;
        for (int i = 0; i < live_count; i++)
          if (table_model[i].remaining == 0) r.removed++;
          else begin
            table_model[j] = table_model[i];
            j++;
          end
        live_count = j;
      end
      slet_pkg::MODE_REMOVE: begin
        if (hit < 0) r.status = slet_pkg::ST_MISSING;
        else begin
          for (int i = hit; i + 1 < live_count; i++) table_model[i] = table_model[i+1];
          live_count--;
        end
      end
      slet_pkg::MODE_READ: begin
        if (op.ridx < live_count) begin
          r.valid = 1'b1;
          r.ex = table_model[op.ridx].x;
          r.ey = table_model[op.ridx].y;
          r.es = table_model[op.ridx].start;
          r.er = table_model[op.ridx].remaining;
        end
      end
      default: ;
    endcase
    r.occ = live_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // driver: holds start until the block takes the item
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(apply_op(pending_ops.pop_front()));
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_mode <= pending_ops[0].mode;
          in_key_x <= pending_ops[0].kx;
          in_key_y <= pending_ops[0].ky;
          in_lifetime <= pending_ops[0].life;
          in_read_index <= pending_ops[0].ridx;
        end else start <= 1'b0;
      end else if (!start && pending_ops.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        in_mode <= pending_ops[0].mode;
        in_key_x <= pending_ops[0].kx;
        in_key_y <= pending_ops[0].ky;
        in_lifetime <= pending_ops[0].life;
        in_read_index <= pending_ops[0].ridx;
      end
    end
  end

  // monitor: compare every strobed result with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_removed_count !== want.removed)
          report_mismatch("removed_count", out_removed_count, want.removed);
        if (out_entry_valid !== want.valid)
          report_mismatch("entry_valid", out_entry_valid, want.valid);
        if (out_entry_x !== want.ex) report_mismatch("entry_x", out_entry_x, want.ex);
        if (out_entry_y !== want.ey) report_mismatch("entry_y", out_entry_y, want.ey);
        if (out_entry_start !== want.es)
          report_mismatch("entry_start", out_entry_start, want.es);
        if (out_entry_remaining !== want.er)
          report_mismatch("entry_remaining", out_entry_remaining, want.er);
        if (out_occupancy !== want.occ)
          report_mismatch("occupancy", out_occupancy, want.occ);
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic op_t make_op(logic [2:0] m, logic [7:0] x, logic [7:0] y,
                                  logic [15:0] l, logic [3:0] r);
    op_t o;
    o.mode = m; o.kx = x; o.ky = y; o.life = l; o.ridx = r;
    return o;
  endfunction

  // random item: keys from a small pool so duplicates and hits happen often
  function automatic op_t random_op();
    op_t o;
    int  pick;
    o.kx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
    o.ky = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    o.life = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(6));
    o.ridx = 4'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) o.mode = slet_pkg::MODE_INSERT;
    else if (pick < 55) o.mode = slet_pkg::MODE_TICK;
    else if (pick < 63) o.mode = slet_pkg::MODE_PURGE;
    else if (pick < 75) o.mode = slet_pkg::MODE_REMOVE;
    else if (pick < 97) o.mode = slet_pkg::MODE_READ;
    else o.mode = 3'($urandom_range(7, 5));
    return o;
  endfunction

  task automatic run_phase(int idle_pct, int count);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) pending_ops.push_back(random_op());
    while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    live_count = 0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, every mode, full table, duplicate, missing, purge
    pending_ops.push_back(make_op(slet_pkg::MODE_READ, 8'd0, 8'd0, 16'd0, 4'd0));
    pending_ops.push_back(make_op(slet_pkg::MODE_PURGE, 8'd0, 8'd0, 16'd0, 4'd0));
    pending_ops.push_back(make_op(slet_pkg::MODE_REMOVE, 8'hff, 8'hff, 16'd0, 4'd0));
    pending_ops.push_back(make_op(slet_pkg::MODE_INSERT, 8'hff, 8'hff, 16'hffff, 4'd0));
    pending_ops.push_back(make_op(slet_pkg::MODE_INSERT, 8'hff, 8'hff, 16'd1, 4'd0));
    pending_ops.push_back(make_op(slet_pkg::MODE_INSERT, 8'd0, 8'd0, 16'd0, 4'd0));
    for (int i = 0; i < 14; i++)
      pending_ops.push_back(make_op(slet_pkg::MODE_INSERT, 8'(i + 1), 8'h55,
                                    16'(i % 3), 4'd0));
    pending_ops.push_back(make_op(slet_pkg::MODE_READ, 8'd0, 8'd0, 16'd0, 4'd15));
    pending_ops.push_back(make_op(slet_pkg::MODE_TICK, 8'd0, 8'd0, 16'd0, 4'd0));
    pending_ops.push_back(make_op(slet_pkg::MODE_PURGE, 8'd0, 8'd0, 16'd0, 4'd0));
    pending_ops.push_back(make_op(3'd7, 8'hff, 8'hff, 16'hffff, 4'hf));
    pending_ops.push_back(make_op(slet_pkg::MODE_READ, 8'd0, 8'd0, 16'd0, 4'd0));
    while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk);
    run_phase(0, 350);
    run_phase(85, 300);
    run_phase(0, 300);
    run_phase(38, 300);
    repeat (2 * DEPTH + 10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
